@@ sv/cgb_pkg.sv @@
// Shared constants, types and decode function for the cursor text gap buffer.
`default_nettype none

package cgb_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = (CNT_W + 1 > 11) ? CNT_W + 1 : 11;

  localparam int CMD_W = 3;
  localparam int CHAR_W = 8;
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;
  localparam int STAT_W = 2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BOUNDARY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_LEFT,
    OP_RIGHT,
    OP_BACK,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } item_t;

  function automatic op_e decode_cmd(input logic [CMD_W-1:0] cmd);
    op_e op;
    case (cmd)
      CMD_INSERT: op = OP_INSERT;
      CMD_LEFT:   op = OP_LEFT;
      CMD_RIGHT:  op = OP_RIGHT;
      CMD_BACK:   op = OP_BACK;
      CMD_READ:   op = OP_READ;
      default:    op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

@@ sv/cgb_front.sv @@
// Front end: accepts commands, decodes them and hands them to the queue.
`default_nettype none

module cgb_front
  import cgb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [CHAR_W-1:0] char_in_i,
  input  wire logic [IDX_W-1:0]  read_index_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output item_t                  q_item_o
);

  logic  hold_valid_q, hold_valid_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = hold_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = hold_valid_q && !q_full_i;
  assign q_item_o   = item_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (q_push_o) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op  <= decode_cmd(command_i);
      item_q.ch  <= char_in_i;
      item_q.idx <= read_index_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/cgb_queue.sv @@
// Short queue of decoded commands between the front end and the back end.
`default_nettype none

module cgb_queue
  import cgb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  item_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with an empty count");

endmodule

`default_nettype wire

@@ sv/cgb_back.sv @@
// Back end: the two stack memories, their counts and the result register.
`default_nettype none

module cgb_back
  import cgb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire item_t              q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CHAR_W-1:0]       char_out_o,
  output logic [LEN_W-1:0]        text_length_o,
  output logic [LEN_W-1:0]        cursor_pos_o,
  output logic [STAT_W-1:0]       status_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic              state_q, state_d;
  logic [CNT_W-1:0]  lc_q, lc_d;
  logic [CNT_W-1:0]  rc_q, rc_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  op_e               op_q, op_d;
  logic              sel_q, sel_d;

  logic [CHAR_W-1:0] left_mem [CAPACITY];
  logic [CHAR_W-1:0] right_mem [CAPACITY];
  logic [CHAR_W-1:0] lrdata_q, rrdata_q;
  logic              lwe, lre, rwe, rre;
  logic [ADDR_W-1:0] lwaddr, lraddr, rwaddr, rraddr;
  logic [CHAR_W-1:0] lwdata, rwdata;

  logic [SUM_W-1:0]  sum, lc_x, rc_x, idx_x, cap_x;
  logic              out_free, start, load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign start    = (state_q == S_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = start;

  always_comb begin
    lc_x  = SUM_W'(lc_q);
    rc_x  = SUM_W'(rc_q);
    sum   = lc_x + rc_x;
    idx_x = SUM_W'(q_item_i.idx);
    cap_x = SUM_W'(CAPACITY);

    state_d     = state_q;
    lc_d        = lc_q;
    rc_d        = rc_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    len_d       = len_q;
    pos_d       = pos_q;
    stat_d      = stat_q;
    op_d        = op_q;
    sel_d       = sel_q;
    load        = 1'b0;
    lwe         = 1'b0;
    lre         = 1'b0;
    rwe         = 1'b0;
    rre         = 1'b0;
    lwaddr      = lc_q[ADDR_W-1:0];
    rwaddr      = rc_q[ADDR_W-1:0];
    lraddr      = q_item_i.idx[ADDR_W-1:0];
    rraddr      = ADDR_W'(sum - idx_x - 1'b1);
    lwdata      = q_item_i.ch;
    rwdata      = lrdata_q;

    if (start) begin
      op_d = q_item_i.op;
      case (q_item_i.op)
        OP_INSERT: begin
          load   = 1'b1;
          stat_d = ST_DONE;
          if (sum >= cap_x) begin
            stat_d = ST_FULL;
          end else begin
            lwe  = 1'b1;
            lc_d = lc_q + 1'b1;
          end
        end
        OP_LEFT: begin
          if (lc_q == '0 || rc_x >= cap_x) begin
            load   = 1'b1;
            stat_d = ST_BOUNDARY;
          end else begin
            lre     = 1'b1;
            lraddr  = ADDR_W'(lc_q - 1'b1);
            state_d = S_WAIT;
          end
        end
        OP_RIGHT: begin
          if (rc_q == '0 || lc_x >= cap_x) begin
            load   = 1'b1;
            stat_d = ST_BOUNDARY;
          end else begin
            rre     = 1'b1;
            rraddr  = ADDR_W'(rc_q - 1'b1);
            state_d = S_WAIT;
          end
        end
        OP_BACK: begin
          load   = 1'b1;
          stat_d = ST_DONE;
          if (lc_q == '0) begin
            stat_d = ST_BOUNDARY;
          end else begin
            lc_d = lc_q - 1'b1;
          end
        end
        OP_READ: begin
          if (idx_x < lc_x) begin
            lre     = 1'b1;
            sel_d   = 1'b0;
            state_d = S_WAIT;
          end else if (idx_x < sum) begin
            rre     = 1'b1;
            sel_d   = 1'b1;
            state_d = S_WAIT;
          end else begin
            load   = 1'b1;
            stat_d = ST_RANGE;
          end
        end
        default: begin
          load   = 1'b1;
          stat_d = ST_DONE;
        end
      endcase
      char_d = '0;
    end else if (state_q == S_WAIT) begin
      state_d = S_IDLE;
      load    = 1'b1;
      stat_d  = ST_DONE;
      char_d  = '0;
      case (op_q)
        OP_LEFT: begin
          rwe  = 1'b1;
          lc_d = lc_q - 1'b1;
          rc_d = rc_q + 1'b1;
        end
        OP_RIGHT: begin
          lwe    = 1'b1;
          lwdata = rrdata_q;
          lc_d   = lc_q + 1'b1;
          rc_d   = rc_q - 1'b1;
        end
        OP_READ: begin
          char_d = sel_q ? rrdata_q : lrdata_q;
        end
        default: begin
          char_d = '0;
        end
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
      len_d       = LEN_W'(lc_d + rc_d);
      pos_d       = LEN_W'(lc_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lc_q        <= '0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lc_q        <= lc_d;
      rc_q        <= rc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    len_q  <= len_d;
    pos_q  <= pos_d;
    stat_q <= stat_d;
    op_q   <= op_d;
    sel_q  <= sel_d;
  end

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      left_mem[lwaddr] <= lwdata;
    end
    if (lre) begin
      lrdata_q <= left_mem[lraddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rwe) begin
      right_mem[rwaddr] <= rwdata;
    end
    if (rre) begin
      rrdata_q <= right_mem[rraddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_out_o    = char_q;
  assign text_length_o = len_q;
  assign cursor_pos_o  = pos_q;
  assign status_o      = stat_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SUM_W'(lc_q) + SUM_W'(rc_q)) <= SUM_W'(CAPACITY))
    else $error("text length exceeds capacity");

  a_wait_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> !out_valid_q)
    else $error("pending memory read with an occupied result register");

  a_wait_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |=> (state_q == S_IDLE) && out_valid_q)
    else $error("memory read did not complete in one cycle");

endmodule

`default_nettype wire

@@ sv/cursor_text_gap_buffer.sv @@
// Top level of the cursor text gap buffer line editor.
`default_nettype none

// A line of up to 1024 bytes with a cursor, held as two stacks in on-chip
// memory: the bytes left of the cursor and the bytes right of it. Each
// transaction on the input channel carries one command (insert, cursor left,
// cursor right, backspace or read at a position) and yields exactly one
// result transaction with the byte read, the text length, the cursor
// position and a status. A command passes a decode register and a two-entry
// queue before the execution unit. Insert, backspace, unknown codes and every
// refused command complete in the execution unit without a memory read;
// cursor moves and reads pass through a wait state for the registered read
// port of the stack memories. The memories need no clearing after reset.
module cursor_text_gap_buffer
  import cgb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [CHAR_W-1:0] char_in_i,
  input  wire logic [IDX_W-1:0]  read_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAR_W-1:0]      char_out_o,
  output logic [LEN_W-1:0]       text_length_o,
  output logic [LEN_W-1:0]       cursor_pos_o,
  output logic [STAT_W-1:0]      status_o
);

  logic  q_full, q_push, q_valid, q_pop;
  item_t push_item, head_item;

  cgb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .char_in_i    (char_in_i),
    .read_index_i (read_index_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  cgb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  cgb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (head_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_pos_o  (cursor_pos_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

@@ verif/cursor_text_gap_buffer_tb.sv @@
// Self-checking testbench for the cursor text gap buffer line editor.
`timescale 1ns / 100ps

module cursor_text_gap_buffer_tb;
  import cgb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int NUM_DIRECTED = 21;
  localparam int NUM_RANDOM = 400;
  localparam int HOLD_OFF_AT = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT = 900_000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
    logic [STAT_W-1:0] st;
  } line_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic              typed;
    line_result_t      res;
  } edit_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CMD_W-1:0]  command_i;
  logic [CHAR_W-1:0] char_in_i;
  logic [IDX_W-1:0]  read_index_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CHAR_W-1:0] char_out_o;
  logic [LEN_W-1:0]  text_length_o;
  logic [LEN_W-1:0]  cursor_pos_o;
  logic [STAT_W-1:0] status_o;

  logic [CHAR_W-1:0] left_text [CAPACITY];
  logic [CHAR_W-1:0] right_text [CAPACITY];
  int                left_len;
  int                right_len;

  line_result_t      expected_results [$];
  edit_row_t         edit_rows [NUM_DIRECTED];
  int                mismatch_count;
  int                results_seen;
  int                cycle_count;
  bit                tx_quiet;
  bit                rx_quiet;

  cursor_text_gap_buffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .char_in_i     (char_in_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_pos_o  (cursor_pos_o),
    .status_o      (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic line_result_t edit_line(input logic [CMD_W-1:0] cmd,
                                             input logic [CHAR_W-1:0] ch,
                                             input logic [IDX_W-1:0] idx);
    line_result_t r;
    int pos;
    r = '0;
    pos = int'(idx);
    case (cmd)
      CMD_INSERT: begin
        if (left_len + right_len >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          left_text[left_len] = ch;
          left_len++;
        end
      end
      CMD_LEFT: begin
        if (left_len == 0 || right_len >= CAPACITY) begin
          r.st = ST_BOUNDARY;
        end else begin
          left_len--;
          right_text[right_len] = left_text[left_len];
          right_len++;
        end
      end
      CMD_RIGHT: begin
        if (right_len == 0 || left_len >= CAPACITY) begin
          r.st = ST_BOUNDARY;
        end else begin
          right_len--;
          left_text[left_len] = right_text[right_len];
          left_len++;
        end
      end
      CMD_BACK: begin
        if (left_len == 0) begin
          r.st = ST_BOUNDARY;
        end else begin
          left_len--;
        end
      end
      CMD_READ: begin
        if (pos < left_len) begin
          r.ch = left_text[pos];
        end else if (pos < left_len + right_len) begin
          r.ch = right_text[right_len - 1 - (pos - left_len)];
        end else begin
          r.st = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    r.len = LEN_W'(left_len + right_len);
    r.pos = LEN_W'(left_len);
    return r;
  endfunction

  function automatic edit_row_t make_row(input logic [CMD_W-1:0] cmd,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [IDX_W-1:0] idx,
                                         input logic typed,
                                         input logic [CHAR_W-1:0] exp_ch,
                                         input int exp_len,
                                         input int exp_pos,
                                         input logic [STAT_W-1:0] exp_st);
    edit_row_t row;
    row.cmd = cmd;
    row.ch = ch;
    row.idx = idx;
    row.typed = typed;
    row.res.ch = exp_ch;
    row.res.len = LEN_W'(exp_len);
    row.res.pos = LEN_W'(exp_pos);
    row.res.st = exp_st;
    return row;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int total;
    int sel;
    total = left_len + right_len;
    sel = $urandom_range(0, 9);
    if (sel < 6 && total > 0) begin
      return IDX_W'($urandom_range(0, total - 1));
    end else if (sel < 8) begin
      return IDX_W'(total + $urandom_range(0, 1) - $urandom_range(0, 1));
    end
    return IDX_W'($urandom);
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx, input logic typed,
                              input line_result_t typed_result);
    int gap;
    line_result_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 39) == 0) begin
      tx_quiet = !tx_quiet;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    char_in_i <= ch;
    read_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = edit_line(cmd, ch, idx);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic send_op(input logic [CMD_W-1:0] cmd);
    if (cmd == CMD_READ) begin
      send_command(cmd, CHAR_W'($urandom), pick_index(), 1'b0, '0);
    end else begin
      send_command(cmd, CHAR_W'($urandom), IDX_W'($urandom), 1'b0, '0);
    end
  endtask

  task automatic send_random_command();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      send_op(CMD_INSERT);
    end else if (sel < 53) begin
      send_op(CMD_LEFT);
    end else if (sel < 66) begin
      send_op(CMD_RIGHT);
    end else if (sel < 76) begin
      send_op(CMD_BACK);
    end else if (sel < 96) begin
      send_op(CMD_READ);
    end else begin
      send_op(CMD_W'($urandom_range(CMD_SPARE5, CMD_SPARE7)));
    end
  endtask

  task automatic check_result(input line_result_t actual);
    line_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: unexpected result transaction ch=%02h len=%0d pos=%0d st=%0d",
                 $realtime, actual.ch, actual.len, actual.pos, actual.st);
      end
    end else begin
      want = expected_results.pop_front();
      if (actual.ch !== want.ch || actual.len !== want.len ||
          actual.pos !== want.pos || actual.st !== want.st) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result %0d expected ch=%02h len=%0d pos=%0d st=%0d",
                   $realtime, results_seen, want.ch, want.len, want.pos, want.st);
          $display("%0t: result %0d actual   ch=%02h len=%0d pos=%0d st=%0d",
                   $realtime, results_seen, actual.ch, actual.len, actual.pos, actual.st);
        end
      end
    end
  endtask

  initial begin
    int hold;
    bit held_off;
    held_off = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = rx_quiet ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 39) == 0) begin
        rx_quiet = !rx_quiet;
      end
      if (!held_off && results_seen >= HOLD_OFF_AT) begin
        hold = HOLD_OFF_CYCLES;
        held_off = 1'b1;
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_result('{char_out_o, text_length_o, cursor_pos_o, status_o});
      results_seen++;
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      left_text[i] = '0;
      right_text[i] = '0;
    end
    left_len = 0;
    right_len = 0;
    mismatch_count = 0;
    results_seen = 0;
    cycle_count = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_INSERT;
    char_in_i = '0;
    read_index_i = '0;

    edit_rows[0]  = make_row(CMD_LEFT,   8'h3c, 10'd0,    1'b1, 8'h00, 0, 0, ST_BOUNDARY);
    edit_rows[1]  = make_row(CMD_RIGHT,  8'hc3, 10'd1023, 1'b1, 8'h00, 0, 0, ST_BOUNDARY);
    edit_rows[2]  = make_row(CMD_BACK,   8'hff, 10'd512,  1'b1, 8'h00, 0, 0, ST_BOUNDARY);
    edit_rows[3]  = make_row(CMD_READ,   8'h00, 10'd0,    1'b1, 8'h00, 0, 0, ST_RANGE);
    edit_rows[4]  = make_row(CMD_READ,   8'hff, 10'd1023, 1'b1, 8'h00, 0, 0, ST_RANGE);
    edit_rows[5]  = make_row(CMD_SPARE5, 8'h55, 10'd341,  1'b1, 8'h00, 0, 0, ST_DONE);
    edit_rows[6]  = make_row(CMD_SPARE7, 8'haa, 10'd682,  1'b1, 8'h00, 0, 0, ST_DONE);
    edit_rows[7]  = make_row(CMD_INSERT, 8'hff, 10'd0,    1'b1, 8'h00, 1, 1, ST_DONE);
    edit_rows[8]  = make_row(CMD_INSERT, 8'h00, 10'd1023, 1'b1, 8'h00, 2, 2, ST_DONE);
    edit_rows[9]  = make_row(CMD_INSERT, 8'ha5, 10'd0,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[10] = make_row(CMD_LEFT,   8'h00, 10'd0,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[11] = make_row(CMD_LEFT,   8'hff, 10'd1023, 1'b0, '0, 0, 0, ST_DONE);
    edit_rows[12] = make_row(CMD_READ,   8'h00, 10'd0,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[13] = make_row(CMD_READ,   8'h00, 10'd1,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[14] = make_row(CMD_READ,   8'h00, 10'd2,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[15] = make_row(CMD_READ,   8'h00, 10'd3,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[16] = make_row(CMD_RIGHT,  8'h5a, 10'd5,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[17] = make_row(CMD_BACK,   8'h00, 10'd0,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[18] = make_row(CMD_SPARE6, 8'h0f, 10'd0,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[19] = make_row(CMD_INSERT, 8'h5a, 10'd0,    1'b0, '0, 0, 0, ST_DONE);
    edit_rows[20] = make_row(CMD_READ,   8'h00, 10'd1023, 1'b0, '0, 0, 0, ST_DONE);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_command(edit_rows[i].cmd, edit_rows[i].ch, edit_rows[i].idx,
                   edit_rows[i].typed, edit_rows[i].res);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_random_command();
    end

    // Fill the line to capacity, then walk the cursor across all of it and empty it.
    while (left_len + right_len < CAPACITY) begin
      send_op(CMD_INSERT);
      if ($urandom_range(0, 31) == 0) begin
        send_op(CMD_READ);
      end
    end
    send_op(CMD_INSERT);
    send_op(CMD_RIGHT);
    send_command(CMD_READ, 8'h00, 10'd1023, 1'b0, '0);
    send_command(CMD_READ, 8'hff, 10'd0, 1'b0, '0);
    while (left_len > 0) begin
      send_op(CMD_LEFT);
      if ($urandom_range(0, 31) == 0) begin
        send_op(CMD_READ);
      end
    end
    send_op(CMD_LEFT);
    send_op(CMD_BACK);
    send_op(CMD_INSERT);
    send_command(CMD_READ, 8'h00, 10'd1023, 1'b0, '0);
    while (right_len > 0) begin
      send_op(CMD_RIGHT);
      if ($urandom_range(0, 31) == 0) begin
        send_op(CMD_READ);
      end
    end
    while (left_len > 0) begin
      send_op(CMD_BACK);
      if ($urandom_range(0, 31) == 0) begin
        send_op(CMD_READ);
      end
    end
    send_op(CMD_BACK);
    send_command(CMD_READ, 8'h00, 10'd0, 1'b0, '0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cgb_pkg.sv
sv/cgb_front.sv
sv/cgb_queue.sv
sv/cgb_back.sv
sv/cursor_text_gap_buffer.sv
verif/cursor_text_gap_buffer_tb.sv
